>>> rtl/tli_pkg.sv
// Shared types and constants for the table linear interpolator.
// Used by tli_table, tli_divider and table_linear_interpolator; no dependencies.
package tli_pkg;

  localparam int DATA_W          = 32;
  localparam int DEPTH_DEFAULT   = 256;
  localparam int VALUE_W_DEFAULT = 32;
  localparam int CFG_W           = 9;
  localparam int IDX_W           = 8;
  localparam int STATUS_W        = 3;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // word index of the points_in_use register (paddr[2])
  localparam logic [0:0] REG_POINTS = 1'b0;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_BELOW = 3'd1,
    ST_ABOVE = 3'd2,
    ST_FEW   = 3'd3,
    ST_SAT   = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } point_t;

endpackage

>>> rtl/table_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to TABLE_DEPTH signed Q16.16 breakpoints.
// A load word writes one breakpoint when entry_index is below TABLE_DEPTH. A query word
// reads the two end points and then takes the binary-search steps (ceil(log2(n-1)), 7 or 8
// at 256 points), each one read of the single table port, before a bit-serial divider forms
// the quotient. A query on fewer than two points answers without reading the table; other
// error answers and exact end-point hits return once both end points are read. One word is
// in flight at a time; a finished result sits in the output register so the next word can
// be taken while it waits. The table is not cleared at reset: load every entry below
// points_in_use before querying.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = tli_pkg::VALUE_W_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic [tli_pkg::IDX_W-1:0]              entry_index_i,
  input  logic signed [tli_pkg::DATA_W-1:0]      point_x_i,
  input  logic signed [tli_pkg::DATA_W-1:0]      point_y_i,
  input  logic signed [tli_pkg::DATA_W-1:0]      query_x_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [tli_pkg::DATA_W-1:0]      value_o,
  output logic [tli_pkg::STATUS_W-1:0]           status_o,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [tli_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [tli_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [tli_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int W   = tli_pkg::DATA_W;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = tli_pkg::CFG_W;
  localparam logic signed [W+1:0] VMAX = (34'sd1 <<< (VALUE_WIDTH - 1)) - 34'sd1;
  localparam logic signed [W+1:0] VMIN = -VMAX - 34'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_SRCH, S_DIFF, S_MUL, S_DVS, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  // configuration register
  logic [NW-1:0] points_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == tli_pkg::REG_POINTS);
  assign prdata = (paddr[2] == tli_pkg::REG_POINTS) ? tli_pkg::APB_DATA_W'(points_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= '0;
    end else if (cfg_wr) begin
      points_q <= pwdata[NW-1:0];
    end
  end

  // input handshake
  logic accept, load_ok;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign load_ok    = 32'(entry_index_i) < 32'(TABLE_DEPTH);

  logic [NW-1:0] n_lim;
  assign n_lim = (32'(points_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : points_q;

  // datapath registers
  logic signed [W-1:0]   q_q, xlo_q, ylo_q, xhi_q, yhi_q;
  logic [NW-1:0]         lo_q, hi_q, mid_q;
  logic [W-1:0]          a_q, bm_q, d_q;
  logic                  neg_q;
  logic [2*W-1:0]        prod_q;
  logic signed [W+1:0]   res_q;
  tli_pkg::status_e      st_q;
  logic                  out_valid_q;
  logic signed [W-1:0]   value_q;
  tli_pkg::status_e      status_q;

  // move the finished answer into the output register once it is free
  logic out_load;
  assign out_load = (state_q == S_OUT) & (~out_valid_q | ~out_stall_i);

  // table
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  tli_pkg::point_t mem_wdata, mem_rdata;

  assign mem_we    = accept & (func_i == tli_pkg::FUNC_LOAD) & load_ok;
  assign mem_wdata = '{x: point_x_i, y: point_y_i};

  tli_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // search step
  logic          go_hi, more_f, more_n;
  logic [NW-1:0] lo_n, hi_n, mid_f, mid_n;
  logic [NW:0]   sum_n;

  assign mid_f  = hi_q >> 1;
  assign more_f = hi_q > NW'(1);
  assign go_hi  = q_q < mem_rdata.x;
  assign lo_n   = go_hi ? lo_q : mid_q;
  assign hi_n   = go_hi ? mid_q : hi_q;
  assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n  = sum_n[NW:1];
  assign more_n = (hi_n - lo_n) > NW'(1);

  always_comb begin
    unique case (state_q)
      S_IDLE:  mem_addr = (func_i == tli_pkg::FUNC_LOAD) ? AW'(entry_index_i) : '0;
      S_FIRST: mem_addr = AW'(hi_q);
      S_LAST:  mem_addr = AW'(mid_f);
      S_SRCH:  mem_addr = AW'(mid_n);
      default: mem_addr = '0;
    endcase
  end

  // segment differences; the search keeps x_lo <= q < x_hi, so a is non-negative and d is positive
  logic signed [W:0] a_w, b_w, d_w, bm_w;
  assign a_w  = (W+1)'(q_q) - (W+1)'(xlo_q);
  assign b_w  = (W+1)'(yhi_q) - (W+1)'(ylo_q);
  assign d_w  = (W+1)'(xhi_q) - (W+1)'(xlo_q);
  assign bm_w = b_w[W] ? -b_w : b_w;

  logic [2*W-1:0] prod_d;
  assign prod_d = a_q * bm_q;

  // divider
  logic          div_done;
  logic [W-1:0]  quot;

  tli_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DVS),
    .dividend_i (prod_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // clip to the value range
  logic signed [W+1:0] sat_v;
  tli_pkg::status_e    sat_st;

  always_comb begin
    sat_v  = res_q;
    sat_st = st_q;
    if (st_q == tli_pkg::ST_OK) begin
      if (res_q > VMAX) begin
        sat_v  = VMAX;
        sat_st = tli_pkg::ST_SAT;
      end else if (res_q < VMIN) begin
        sat_v  = VMIN;
        sat_st = tli_pkg::ST_SAT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_q         <= '0;
      xlo_q       <= '0;
      ylo_q       <= '0;
      xhi_q       <= '0;
      yhi_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      a_q         <= '0;
      bm_q        <= '0;
      d_q         <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      res_q       <= '0;
      st_q        <= tli_pkg::ST_OK;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      status_q    <= tli_pkg::ST_OK;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && func_i == tli_pkg::FUNC_QUERY) begin
            q_q  <= query_x_i;
            lo_q <= '0;
            hi_q <= n_lim - NW'(1);
            if (n_lim < NW'(2)) begin
              res_q   <= '0;
              st_q    <= tli_pkg::ST_FEW;
              state_q <= S_OUT;
            end else begin
              state_q <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          xlo_q   <= mem_rdata.x;
          ylo_q   <= mem_rdata.y;
          state_q <= S_LAST;
        end
        S_LAST: begin
          xhi_q <= mem_rdata.x;
          yhi_q <= mem_rdata.y;
          priority if (q_q == xlo_q) begin
            st_q    <= tli_pkg::ST_OK;
            res_q   <= (W+2)'(ylo_q);
            state_q <= S_OUT;
          end else if (q_q == mem_rdata.x) begin
            st_q    <= tli_pkg::ST_OK;
            res_q   <= (W+2)'(mem_rdata.y);
            state_q <= S_OUT;
          end else if (q_q < xlo_q) begin
            st_q    <= tli_pkg::ST_BELOW;
            res_q   <= '0;
            state_q <= S_OUT;
          end else if (q_q > mem_rdata.x) begin
            st_q    <= tli_pkg::ST_ABOVE;
            res_q   <= '0;
            state_q <= S_OUT;
          end else if (more_f) begin
            st_q    <= tli_pkg::ST_OK;
            mid_q   <= mid_f;
            state_q <= S_SRCH;
          end else begin
            st_q    <= tli_pkg::ST_OK;
            state_q <= S_DIFF;
          end
        end
        S_SRCH: begin
          lo_q <= lo_n;
          hi_q <= hi_n;
          if (go_hi) begin
            xhi_q <= mem_rdata.x;
            yhi_q <= mem_rdata.y;
          end else begin
            xlo_q <= mem_rdata.x;
            ylo_q <= mem_rdata.y;
          end
          if (more_n) begin
            mid_q <= mid_n;
          end else begin
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          a_q     <= a_w[W-1:0];
          bm_q    <= bm_w[W-1:0];
          d_q     <= d_w[W-1:0];
          neg_q   <= b_w[W];
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= prod_d;
          state_q <= S_DVS;
        end
        S_DVS: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_q   <= neg_q ? (W+2)'(ylo_q) - (W+2)'(quot) : (W+2)'(ylo_q) + (W+2)'(quot);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register frees up
          if (out_load) begin
            value_q  <= sat_v[W-1:0];
            status_q <= sat_st;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

>>> rtl/tli_table.sv
// Breakpoint table: single-port synchronous RAM with a registered read.
// Depends on tli_pkg for the point type.
module tli_table #(
  parameter int TABLE_DEPTH = tli_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] addr_i,
  input  tli_pkg::point_t               wdata_i,
  output tli_pkg::point_t               rdata_o
);

  tli_pkg::point_t mem [TABLE_DEPTH];
  tli_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tli_divider.sv
// Restoring radix-2 divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Caller guarantees dividend[63:32] < divisor. Depends on tli_pkg for widths.
module tli_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2*tli_pkg::DATA_W-1:0]  dividend_i,
  input  logic [tli_pkg::DATA_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [tli_pkg::DATA_W-1:0]    quotient_o
);

  localparam int W   = tli_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_q, quo_q, div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [W:0]       trial;
  logic             fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        rem_q  <= dividend_i[2*W-1:W];
        quo_q  <= dividend_i[W-1:0];
        div_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        // shift in the next dividend bit, subtract when the divisor fits
        rem_q  <= fits ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
        quo_q  <= {quo_q[W-2:0], fits};
        cnt_q  <= cnt_q + CNT_W'(1);
        done_q <= (cnt_q == CNT_W'(W - 1));
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
